>>> rtl/core/sm83alu_pkg.sv
// Package for the SM83 ALU: operation codes, flag bit positions and the
// request/response structs. No dependencies.
package sm83alu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLC   = 5'd10,
		OP_RRC   = 5'd11,
		OP_RL    = 5'd12,
		OP_RR    = 5'd13,
		OP_SLA   = 5'd14,
		OP_SRA   = 5'd15,
		OP_SRL   = 5'd16,
		OP_SWAP  = 5'd17,
		OP_BIT   = 5'd18,
		OP_RES   = 5'd19,
		OP_SET   = 5'd20,
		OP_ADD16 = 5'd21
	} op_t;

	// flag bit positions: Z N H C
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	typedef struct packed {
		logic [4:0]  operation;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} req_t;

	typedef struct packed {
		logic [15:0] result;
		logic [3:0]  flags_out;
	} rsp_t;

endpackage

>>> rtl/core/sm83_alu_with_flags_unit.sv
// SM83 ALU with flags: registered request stage, combinational ALU,
// registered result stage. Depends on sm83alu_pkg.

// Takes one request per clock: a request is taken on any edge with start
// high (busy never rises, since nothing here waits on the receiver). Each
// request gives exactly one response, on rsp with done high for that one
// cycle, after passing the request register, the combinational ALU and the
// result register. Responses come out in request order. Unused operation
// codes return operand_a and flags_in.
module sm83_alu_with_flags_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sm83alu_pkg::req_t req,
	output logic              done,
	output sm83alu_pkg::rsp_t rsp
);

	logic              valid_s1;
	sm83alu_pkg::req_t req_s1;
	logic              valid_s2;
	sm83alu_pkg::rsp_t rsp_s2;

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        carry_t;
	logic [8:0]  sum9;
	logic [4:0]  sum_lo;
	logic [8:0]  diff9;
	logic [4:0]  diff_lo;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [7:0]  bit_mask;
	logic [7:0]  r8;
	logic [15:0] res_d;
	logic [3:0]  flg_d;
	logic        eight_bit;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_s2 <= '{result: res_d, flags_out: flg_d};
		end
	end

	always_comb begin
		a        = req_s1.operand_a[7:0];
		b        = req_s1.operand_b[7:0];
		cin      = req_s1.flags_in[sm83alu_pkg::FLAG_C];
		carry_t  = (req_s1.operation inside {sm83alu_pkg::OP_ADC, sm83alu_pkg::OP_SBC}) ?
			cin : 1'b0;
		sum9     = {1'b0, a} + {1'b0, b} + {8'd0, carry_t};
		sum_lo   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
		diff9    = {1'b0, a} - {1'b0, b} - {8'd0, carry_t};
		diff_lo  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_t};
		sum17    = {1'b0, req_s1.operand_a} + {1'b0, req_s1.operand_b};
		sum13    = {1'b0, req_s1.operand_a[11:0]} + {1'b0, req_s1.operand_b[11:0]};
		bit_mask = 8'd1 << req_s1.bit_index;

		r8        = a;
		eight_bit = 1'b1;
		flg_d     = req_s1.flags_in;
		case (sm83alu_pkg::op_t'(req_s1.operation))
			sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
				r8    = sum9[7:0];
				flg_d = {sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]};
			end
			sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC: begin
				r8    = diff9[7:0];
				flg_d = {diff9[7:0] == 8'd0, 1'b1, diff_lo[4], diff9[8]};
			end
			sm83alu_pkg::OP_CP: begin
				eight_bit = 1'b0;
				flg_d     = {diff9[7:0] == 8'd0, 1'b1, diff_lo[4], diff9[8]};
			end
			sm83alu_pkg::OP_AND: begin
				r8    = a & b;
				flg_d = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			sm83alu_pkg::OP_XOR: begin
				r8    = a ^ b;
				flg_d = {(a ^ b) == 8'd0, 3'b000};
			end
			sm83alu_pkg::OP_OR: begin
				r8    = a | b;
				flg_d = {(a | b) == 8'd0, 3'b000};
			end
			sm83alu_pkg::OP_INC: begin
				r8    = a + 8'd1;
				flg_d = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
			end
			sm83alu_pkg::OP_DEC: begin
				r8    = a - 8'd1;
				flg_d = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
			end
			sm83alu_pkg::OP_RLC: begin
				r8    = {a[6:0], a[7]};
				flg_d = {a == 8'd0, 2'b00, a[7]};
			end
			sm83alu_pkg::OP_RRC: begin
				r8    = {a[0], a[7:1]};
				flg_d = {a == 8'd0, 2'b00, a[0]};
			end
			sm83alu_pkg::OP_RL: begin
				r8    = {a[6:0], cin};
				flg_d = {{a[6:0], cin} == 8'd0, 2'b00, a[7]};
			end
			sm83alu_pkg::OP_RR: begin
				r8    = {cin, a[7:1]};
				flg_d = {{cin, a[7:1]} == 8'd0, 2'b00, a[0]};
			end
			sm83alu_pkg::OP_SLA: begin
				r8    = {a[6:0], 1'b0};
				flg_d = {a[6:0] == 7'd0, 2'b00, a[7]};
			end
			sm83alu_pkg::OP_SRA: begin
				r8    = {a[7], a[7:1]};
				flg_d = {a[7:1] == 7'd0, 2'b00, a[0]};
			end
			sm83alu_pkg::OP_SRL: begin
				r8    = {1'b0, a[7:1]};
				flg_d = {a[7:1] == 7'd0, 2'b00, a[0]};
			end
			sm83alu_pkg::OP_SWAP: begin
				r8    = {a[3:0], a[7:4]};
				flg_d = {a == 8'd0, 3'b000};
			end
			sm83alu_pkg::OP_BIT: begin
				eight_bit = 1'b0;
				flg_d     = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
			end
			sm83alu_pkg::OP_RES: begin
				r8 = a & ~bit_mask;
			end
			sm83alu_pkg::OP_SET: begin
				r8 = a | bit_mask;
			end
			sm83alu_pkg::OP_ADD16: begin
				eight_bit = 1'b0;
				flg_d     = {req_s1.flags_in[sm83alu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
			end
			default: begin
				// unused codes: no operation
				eight_bit = 1'b0;
			end
		endcase

		if (eight_bit) begin
			res_d = {8'd0, r8};
		end else if (req_s1.operation == sm83alu_pkg::OP_ADD16) begin
			res_d = sum17[15:0];
		end else begin
			res_d = req_s1.operand_a;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	// every response traces back to a request through the request and result registers
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("response without request");

	a_one_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request dropped between stages");

	a_res_set_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (req_s1.operation == sm83alu_pkg::OP_RES ||
			req_s1.operation == sm83alu_pkg::OP_SET)
		|=> rsp.flags_out == $past(req_s1.flags_in))
		else $error("RES/SET changed flags");

	a_byte_ops_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (req_s1.operation == sm83alu_pkg::OP_ADD ||
			req_s1.operation == sm83alu_pkg::OP_SUB ||
			req_s1.operation == sm83alu_pkg::OP_SWAP ||
			req_s1.operation == sm83alu_pkg::OP_RES)
		|=> rsp.result[15:8] == 8'd0)
		else $error("high byte set on 8-bit op");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for sm83_alu_with_flags_unit: directed and random ALU requests,
// each response checked against an in-bench model of the SM83 result and flags.
// Depends on sm83alu_pkg and the DUT only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_REQUESTS = 1024;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam logic [4:0] OP_UNUSED_FIRST = 5'd22;
	localparam logic [4:0] OP_UNUSED_LAST = 5'd31;

	typedef struct {
		sm83alu_pkg::req_t req;
		int unsigned gap;
		bit drain;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sm83alu_pkg::req_t req = '0;
	logic done;
	sm83alu_pkg::rsp_t rsp;

	pending_t pending_q[$];
	sm83alu_pkg::rsp_t alu_expect_q[$];
	int unsigned hold_cycles = 0;
	int unsigned sent_count = 0;
	int unsigned got_count = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic [31:0] ops_seen = '0;

	sm83_alu_with_flags_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial forever #2 clk = ~clk;

	function automatic logic [3:0] flag_word(logic z, logic n, logic h, logic c);
		logic [3:0] w;
		w = '0;
		w[sm83alu_pkg::FLAG_Z] = z;
		w[sm83alu_pkg::FLAG_N] = n;
		w[sm83alu_pkg::FLAG_H] = h;
		w[sm83alu_pkg::FLAG_C] = c;
		return w;
	endfunction

	function automatic sm83alu_pkg::rsp_t alu_predict(sm83alu_pkg::req_t r);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] res8;
		logic [8:0] wide9;
		logic [4:0] nib5;
		logic [16:0] sum17;
		logic [12:0] sum13;
		logic cin;
		logic t;
		sm83alu_pkg::rsp_t o;
		a = r.operand_a[7:0];
		b = r.operand_b[7:0];
		cin = r.flags_in[sm83alu_pkg::FLAG_C];
		o.result = r.operand_a;
		o.flags_out = r.flags_in;
		case (r.operation)
		sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
			t = (r.operation == sm83alu_pkg::OP_ADC) ? cin : 1'b0;
			wide9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
			nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
			o.result = {8'h00, wide9[7:0]};
			o.flags_out = flag_word(wide9[7:0] == 8'h00, 1'b0, nib5[4], wide9[8]);
		end
		sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
			t = (r.operation == sm83alu_pkg::OP_SBC) ? cin : 1'b0;
			// the top bit of the widened difference is the borrow
			wide9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
			nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
			o.flags_out = flag_word(wide9[7:0] == 8'h00, 1'b1, nib5[4], wide9[8]);
			if (r.operation != sm83alu_pkg::OP_CP) o.result = {8'h00, wide9[7:0]};
		end
		sm83alu_pkg::OP_AND, sm83alu_pkg::OP_XOR, sm83alu_pkg::OP_OR: begin
			if (r.operation == sm83alu_pkg::OP_AND) res8 = a & b;
			else if (r.operation == sm83alu_pkg::OP_XOR) res8 = a ^ b;
			else res8 = a | b;
			o.result = {8'h00, res8};
			o.flags_out = flag_word(res8 == 8'h00, 1'b0,
				r.operation == sm83alu_pkg::OP_AND, 1'b0);
		end
		sm83alu_pkg::OP_INC: begin
			res8 = a + 8'h01;
			o.result = {8'h00, res8};
			o.flags_out = flag_word(res8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
		end
		sm83alu_pkg::OP_DEC: begin
			res8 = a - 8'h01;
			o.result = {8'h00, res8};
			o.flags_out = flag_word(res8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
		end
		sm83alu_pkg::OP_RLC, sm83alu_pkg::OP_RRC, sm83alu_pkg::OP_RL, sm83alu_pkg::OP_RR,
		sm83alu_pkg::OP_SLA, sm83alu_pkg::OP_SRA, sm83alu_pkg::OP_SRL,
		sm83alu_pkg::OP_SWAP: begin
			case (r.operation)
			sm83alu_pkg::OP_RLC: res8 = {a[6:0], a[7]};
			sm83alu_pkg::OP_RRC: res8 = {a[0], a[7:1]};
			sm83alu_pkg::OP_RL: res8 = {a[6:0], cin};
			sm83alu_pkg::OP_RR: res8 = {cin, a[7:1]};
			sm83alu_pkg::OP_SLA: res8 = {a[6:0], 1'b0};
			sm83alu_pkg::OP_SRA: res8 = {a[7], a[7:1]};
			sm83alu_pkg::OP_SRL: res8 = {1'b0, a[7:1]};
			default: res8 = {a[3:0], a[7:4]};
			endcase
			if (r.operation == sm83alu_pkg::OP_SWAP) t = 1'b0;
			else if (r.operation inside {sm83alu_pkg::OP_RLC, sm83alu_pkg::OP_RL,
					sm83alu_pkg::OP_SLA})
				t = a[7];
			else t = a[0];
			o.result = {8'h00, res8};
			o.flags_out = flag_word(res8 == 8'h00, 1'b0, 1'b0, t);
		end
		sm83alu_pkg::OP_BIT: begin
			o.flags_out = flag_word(!a[r.bit_index], 1'b0, 1'b1, cin);
		end
		sm83alu_pkg::OP_RES: begin
			res8 = a;
			res8[r.bit_index] = 1'b0;
			o.result = {8'h00, res8};
		end
		sm83alu_pkg::OP_SET: begin
			res8 = a;
			res8[r.bit_index] = 1'b1;
			o.result = {8'h00, res8};
		end
		sm83alu_pkg::OP_ADD16: begin
			sum17 = {1'b0, r.operand_a} + {1'b0, r.operand_b};
			sum13 = {1'b0, r.operand_a[11:0]} + {1'b0, r.operand_b[11:0]};
			o.result = sum17[15:0];
			o.flags_out = flag_word(r.flags_in[sm83alu_pkg::FLAG_Z], 1'b0, sum13[12],
				sum17[16]);
		end
		default: ;
		endcase
		return o;
	endfunction

	task automatic add_request(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b,
			input logic [2:0] bi, input logic [3:0] fl, input int unsigned gap, input bit drain);
		pending_t p;
		p.req.operation = op;
		p.req.operand_a = a;
		p.req.operand_b = b;
		p.req.bit_index = bi;
		p.req.flags_in = fl;
		p.gap = gap;
		p.drain = drain;
		pending_q.push_back(p);
	endtask

	// random operand biased toward the carry and half-carry boundaries
	function automatic logic [15:0] pick_operand();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(0, 7))
		0: v[7:0] = 8'h00;
		1: v[7:0] = 8'hFF;
		2: v[3:0] = 4'hF;
		3: v[3:0] = 4'h0;
		4: v[11:0] = 12'hFFF;
		5: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		default: ;
		endcase
		return v;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			hold_cycles <= 0;
		end else begin
			if (start && !busy) begin
				alu_expect_q.push_back(alu_predict(req));
				ops_seen[req.operation] <= 1'b1;
				sent_count <= sent_count + 1;
			end
			if (start && busy) begin
				// request held until taken
			end else if (hold_cycles != 0) begin
				start <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (pending_q.size() == 0) begin
				start <= 1'b0;
			end else if (pending_q[0].gap != 0) begin
				start <= 1'b0;
				hold_cycles <= pending_q[0].gap - 1;
				pending_q[0].gap = 0;
			end else if (pending_q[0].drain && (start || sent_count != got_count)) begin
				start <= 1'b0;
			end else begin
				req <= pending_q[0].req;
				start <= 1'b1;
				void'(pending_q.pop_front());
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		sm83alu_pkg::rsp_t want;
		if (!arst_n) begin
			got_count <= 0;
		end else if (done) begin
			if (alu_expect_q.size() == 0) begin
				$error("unexpected response: result %h flags_out %h", rsp.result, rsp.flags_out);
				mismatches++;
			end else begin
				want = alu_expect_q.pop_front();
				if (rsp.result !== want.result) begin
					$error("result: expected %h, got %h", want.result, rsp.result);
					mismatches++;
				end
				if (rsp.flags_out !== want.flags_out) begin
					$error("flags_out: expected %h, got %h", want.flags_out, rsp.flags_out);
					mismatches++;
				end
				got_count <= got_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		bit drain;
		bit no_idle;
		logic [4:0] op;
		logic [15:0] a;
		logic [15:0] b;

		// directed: boundaries, carry-in use, CP equality, pass-through cases
		add_request(sm83alu_pkg::OP_ADD, 16'h12FF, 16'hAB01, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_ADC, 16'h000F, 16'h0000, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_ADC, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111, 0, 0);
		add_request(sm83alu_pkg::OP_SUB, 16'h0010, 16'h0001, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_SBC, 16'h0000, 16'h0000, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_AND, 16'h00F0, 16'h000F, 3'd0, 4'b0101, 0, 0);
		add_request(sm83alu_pkg::OP_XOR, 16'hFFFF, 16'h00FF, 3'd0, 4'b0111, 0, 0);
		add_request(sm83alu_pkg::OP_OR, 16'h0000, 16'hFF00, 3'd0, 4'b1111, 0, 0);
		add_request(sm83alu_pkg::OP_CP, 16'hAB42, 16'h0042, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_CP, 16'h0000, 16'h00FF, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_INC, 16'h00FF, 16'h0000, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_DEC, 16'h0001, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_DEC, 16'hFF00, 16'h0000, 3'd0, 4'b1001, 0, 0);
		add_request(sm83alu_pkg::OP_RLC, 16'h0080, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_RRC, 16'h0001, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_RL, 16'h0080, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_RR, 16'h0001, 16'h0000, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_SLA, 16'h0080, 16'h0000, 3'd0, 4'b0110, 0, 0);
		add_request(sm83alu_pkg::OP_SRA, 16'h0081, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_SRL, 16'h0001, 16'h0000, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_SWAP, 16'h00F0, 16'h0000, 3'd0, 4'b0001, 0, 0);
		add_request(sm83alu_pkg::OP_BIT, 16'h7F7F, 16'h0000, 3'd7, 4'b0101, 0, 0);
		add_request(sm83alu_pkg::OP_RES, 16'hFFFF, 16'h0000, 3'd7, 4'b1010, 0, 0);
		add_request(sm83alu_pkg::OP_SET, 16'hFF00, 16'h0000, 3'd0, 4'b0101, 0, 0);
		add_request(sm83alu_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b0000, 0, 0);
		add_request(sm83alu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1000, 0, 0);
		add_request(OP_UNUSED_FIRST, 16'h1234, 16'h5678, 3'd3, 4'b1010, 0, 0);
		add_request(OP_UNUSED_LAST, 16'hFEDC, 16'hBA98, 3'd5, 4'b0101, 0, 0);

		no_idle = 1'b0;
		for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
			// alternate stretches of back-to-back requests with idle-heavy ones
			if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
			gap = no_idle ? 0 : $urandom_range(0, 10);
			drain = (i == 0) || ($urandom_range(0, 99) == 0);
			if ($urandom_range(0, 19) == 0)
				op = 5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
			else
				op = 5'($urandom_range(sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADD16));
			a = pick_operand();
			b = pick_operand();
			if ($urandom_range(0, 7) == 0) b[7:0] = a[7:0];
			add_request(op, a, b, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
				gap, drain);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start) @(posedge clk);
		while (sent_count != got_count) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (alu_expect_q.size() != 0) begin
			$error("%0d responses never arrived", alu_expect_q.size());
			mismatches++;
		end
		$display("Sent %0d ALU requests covering %0d of 32 operation codes; %0d responses checked.",
			sent_count, $countones(ops_seen), got_count);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
